// ===== sv/multi_channel_offline_detector_assert.svh =====
// Assertion helpers for the detector RTL.
`ifndef MULTI_CHANNEL_OFFLINE_DETECTOR_ASSERT_SVH
`define MULTI_CHANNEL_OFFLINE_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCOD_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MCOD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mcod_pkg.sv =====
package mcod_pkg;

    localparam int TIME_W      = 32;
    localparam int LANE_MAX    = 8;
    localparam int THR_W       = 8;
    localparam int BLINK_W     = 5;
    localparam int CHAN_W      = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    localparam int CHANNELS_DEF    = 8;
    localparam int BLINK_SCANS_DEF = 30;

    localparam logic [CFG_IDX_W-1:0] REG_OFFLINE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 2'd3;

    localparam logic [63:0] RST_OFFLINE = 64'd723401728380240414;
    localparam logic [63:0] RST_SETTLE  = 64'd723401728380306216;
    localparam logic [7:0]  RST_ENABLE  = 8'd247;
    localparam logic [7:0]  RST_PERIOD  = 8'd10;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_BEAT = 1'b1;

    // What the current beat does to the channel lanes and the display.
    typedef struct packed {
        logic              commit;
        logic              scan;
        logic              beat;
        logic [CHAN_W-1:0] chan;
        logic [TIME_W-1:0] now;
    } event_t;

    typedef struct packed {
        logic [LANE_MAX-1:0] flow;
        logic                red;
        logic                buzzer;
    } disp_t;

endpackage

// ===== sv/mcod_lane.sv =====
module mcod_lane #(
    parameter int INDEX = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mcod_pkg::event_t           ev,
    input  logic                       enable,
    input  logic [mcod_pkg::THR_W-1:0] limit,
    input  logic [mcod_pkg::THR_W-1:0] settle,
    output logic                       lost_next
);

    logic [mcod_pkg::TIME_W-1:0] last_heard_reg;
    logic [mcod_pkg::TIME_W-1:0] online_since_reg;
    logic                        lost_reg;
    logic [mcod_pkg::TIME_W-1:0] age_settle;
    logic [mcod_pkg::TIME_W-1:0] age_heard;
    logic                        hit;

    assign hit        = ev.beat && (ev.chan == mcod_pkg::CHAN_W'(INDEX));
    assign age_settle = ev.now - online_since_reg;
    assign age_heard  = ev.now - last_heard_reg;

    always_comb
    begin
        priority if (hit)
        begin
            lost_next = 1'b0;
        end
        else if (ev.scan && enable)
        begin
            // A channel inside its settle window counts as present.
            if (age_settle < mcod_pkg::TIME_W'(settle))
                lost_next = 1'b0;
            else
                lost_next = age_heard > mcod_pkg::TIME_W'(limit);
        end
        else
        begin
            lost_next = lost_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_heard_reg   <= '0;
            online_since_reg <= '0;
            lost_reg         <= 1'b1;
        end
        else if (ev.commit)
        begin
            lost_reg <= lost_next;
            if (hit)
            begin
                last_heard_reg <= ev.now;
                if (lost_reg)
                    online_since_reg <= ev.now;
            end
        end
    end

endmodule

// ===== sv/mcod_display.sv =====
module mcod_display #(
    parameter int BLINK_SCANS = mcod_pkg::BLINK_SCANS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mcod_pkg::event_t              ev,
    input  logic [mcod_pkg::LANE_MAX-1:0] enable,
    input  logic [mcod_pkg::LANE_MAX-1:0] lost,
    output mcod_pkg::disp_t               disp_next
);

    mcod_pkg::disp_t              disp_reg;
    logic [mcod_pkg::BLINK_W-1:0] blink_reg;
    logic [mcod_pkg::BLINK_W-1:0] blink_next;
    logic [mcod_pkg::BLINK_W-1:0] blink_inc;
    logic [mcod_pkg::LANE_MAX-1:0] fault;
    logic                          err;
    logic                          wrap;

    assign fault     = enable & lost;
    assign err       = |fault;
    assign blink_inc = blink_reg + mcod_pkg::BLINK_W'(1);
    assign wrap      = blink_inc == mcod_pkg::BLINK_W'(BLINK_SCANS);

    always_comb
    begin
        disp_next  = disp_reg;
        blink_next = blink_reg;
        if (ev.scan)
        begin
            disp_next.flow   = ~fault;
            disp_next.buzzer = err;
            blink_next       = blink_inc;
            if (wrap)
            begin
                // The red LED blinks while an error persists and goes dark otherwise.
                disp_next.red = err ? ~disp_reg.red : 1'b0;
                blink_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disp_reg  <= '0;
            blink_reg <= '0;
        end
        else if (ev.commit)
        begin
            disp_reg  <= disp_next;
            blink_reg <= blink_next;
        end
    end

endmodule

// ===== sv/multi_channel_offline_detector.sv =====
// A request beat is registered in the request stage, then processed into the
// response register once that register is free or being drained. Throughput: one
// beat per cycle unless rsp_ready holds it back; the state update and all channel
// compares for a beat fit in the single stage between the request and response registers.
// Reset (rst_n, asynchronous, active low) restores the default thresholds, sets
// every lost flag, and clears the time, timestamps, divider and display.
`include "multi_channel_offline_detector_assert.svh"

module multi_channel_offline_detector #(
    parameter int CHANNELS    = mcod_pkg::CHANNELS_DEF,
    parameter int BLINK_SCANS = mcod_pkg::BLINK_SCANS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [mcod_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mcod_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  logic                            req_type,
    input  logic [mcod_pkg::CHAN_W-1:0]     channel,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output logic [mcod_pkg::LANE_MAX-1:0]   lost_mask,
    output logic [mcod_pkg::LANE_MAX-1:0]   flow_leds,
    output logic                            red_led,
    output logic                            buzzer,
    output logic                            scan_done
);

    // Channels beyond eight have no enable bit and never show, so they need no lane.
    localparam int LANES = (CHANNELS < mcod_pkg::LANE_MAX) ? CHANNELS : mcod_pkg::LANE_MAX;

    logic [63:0] offline_reg;
    logic [63:0] settle_reg;
    logic [7:0]  enable_reg;
    logic [7:0]  period_reg;

    logic                        in_valid_reg;
    logic                        in_type_reg;
    logic [mcod_pkg::CHAN_W-1:0] in_chan_reg;

    logic [mcod_pkg::TIME_W-1:0] time_reg;
    logic [mcod_pkg::TIME_W-1:0] time_next;
    logic [7:0]                  div_reg;
    logic [7:0]                  div_next;
    logic [7:0]                  div_inc;

    logic                        advance;
    logic                        tick;
    logic                        scan;
    mcod_pkg::event_t            ev;
    logic [LANES-1:0]            lost_lane;
    logic [mcod_pkg::LANE_MAX-1:0] lost_all;
    mcod_pkg::disp_t             disp_next;

    logic                          rsp_valid_reg;
    logic [mcod_pkg::LANE_MAX-1:0] lost_mask_reg;
    logic [mcod_pkg::LANE_MAX-1:0] flow_leds_reg;
    logic                          red_led_reg;
    logic                          buzzer_reg;
    logic                          scan_done_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offline_reg <= mcod_pkg::RST_OFFLINE;
            settle_reg  <= mcod_pkg::RST_SETTLE;
            enable_reg  <= mcod_pkg::RST_ENABLE;
            period_reg  <= mcod_pkg::RST_PERIOD;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                mcod_pkg::REG_OFFLINE: offline_reg <= cfg_data;
                mcod_pkg::REG_SETTLE:  settle_reg  <= cfg_data;
                mcod_pkg::REG_ENABLE:  enable_reg  <= cfg_data[7:0];
                mcod_pkg::REG_PERIOD:  period_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // The request stage moves on whenever the response register is free or being drained.
    assign advance   = in_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req_ready)
            in_valid_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            in_type_reg <= req_type;
            in_chan_reg <= channel;
        end
    end

    // Tick counter and scan divider. A period of zero scans on every tick.
    assign tick      = in_type_reg == mcod_pkg::REQ_TICK;
    assign time_next = tick ? time_reg + mcod_pkg::TIME_W'(1) : time_reg;
    assign div_inc   = div_reg + 8'd1;
    assign scan      = tick && (div_inc >= period_reg);
    assign div_next  = tick ? (scan ? 8'd0 : div_inc) : div_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
            div_reg  <= '0;
        end
        else if (advance)
        begin
            time_reg <= time_next;
            div_reg  <= div_next;
        end
    end

    always_comb
    begin
        ev.commit = advance;
        ev.scan   = scan;
        ev.beat   = in_type_reg == mcod_pkg::REQ_BEAT;
        ev.chan   = in_chan_reg;
        ev.now    = time_next;
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        mcod_lane #(
            .INDEX (i)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .ev        (ev),
            .enable    (enable_reg[i]),
            .limit     (offline_reg[8*i +: 8]),
            .settle    (settle_reg[8*i +: 8]),
            .lost_next (lost_lane[i])
        );
    end

    assign lost_all = mcod_pkg::LANE_MAX'(lost_lane);

    mcod_display #(
        .BLINK_SCANS (BLINK_SCANS)
    ) u_display (
        .clk       (clk),
        .rst_n     (rst_n),
        .ev        (ev),
        .enable    (enable_reg),
        .lost      (lost_all),
        .disp_next (disp_next)
    );

    // Response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (advance)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lost_mask_reg <= lost_all;
            flow_leds_reg <= disp_next.flow;
            red_led_reg   <= disp_next.red;
            buzzer_reg    <= disp_next.buzzer;
            scan_done_reg <= scan;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign lost_mask = lost_mask_reg;
    assign flow_leds = flow_leds_reg;
    assign red_led   = red_led_reg;
    assign buzzer    = buzzer_reg;
    assign scan_done = scan_done_reg;

    `MCOD_ASSERT_IMPL(a_scan_buzzer, clk, rst_n, rsp_valid && scan_done,
        buzzer == (flow_leds != 8'hFF), "buzzer disagrees with flow LEDs after a scan")
    `MCOD_ASSERT_NEXT(a_time_hold, clk, rst_n, !(advance && tick), $stable(time_reg),
        "tick counter moved without a tick beat")
    `MCOD_ASSERT_NEXT(a_rsp_load, clk, rst_n, advance, rsp_valid,
        "processed beat produced no response")

endmodule

// ===== tb/multi_channel_offline_detector_tb.sv =====
`timescale 1ns / 1ps

module multi_channel_offline_detector_tb;

    import mcod_pkg::*;

    typedef struct packed {
        logic              kind;
        logic [CHAN_W-1:0] ch;
    } beat_t;

    typedef struct packed {
        logic [LANE_MAX-1:0] lost;
        logic [LANE_MAX-1:0] flow;
        logic                red;
        logic                buzz;
        logic                scan;
    } status_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    logic                  req_type = REQ_TICK;
    logic [CHAN_W-1:0]     channel = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    logic [LANE_MAX-1:0]   lost_mask;
    logic [LANE_MAX-1:0]   flow_leds;
    logic                  red_led;
    logic                  buzzer;
    logic                  scan_done;

    // Register copies as the detector should hold them.
    logic [63:0]         limits_cfg = RST_OFFLINE;
    logic [63:0]         settle_cfg = RST_SETTLE;
    logic [7:0]          enable_cfg = RST_ENABLE;
    logic [7:0]          period_cfg = RST_PERIOD;

    // Detector state mirror.
    logic [TIME_W-1:0]   now_ticks = '0;
    logic [TIME_W-1:0]   heard_at [LANE_MAX];
    logic [TIME_W-1:0]   settle_start [LANE_MAX];
    logic [LANE_MAX-1:0] lost_bits = '1;
    logic [7:0]          div_cnt = '0;
    logic [BLINK_W-1:0]  blink_cnt = '0;
    logic                red_state = 1'b0;
    logic [LANE_MAX-1:0] flow_state = '0;
    logic                buzz_state = 1'b0;

    beat_t   pending_beats [$];
    status_t expected_status [$];
    beat_t   next_beat;
    int      beats_sent = 0;
    int      results_seen = 0;
    int      errors = 0;
    int      send_gap = 0;
    int      recv_stall = 0;
    int      hold_asks = 0;
    int      hold_served = 0;
    bit      gapless = 1'b0;

    multi_channel_offline_detector i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_type  (req_type),
        .channel   (channel),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .lost_mask (lost_mask),
        .flow_leds (flow_leds),
        .red_led   (red_led),
        .buzzer    (buzzer),
        .scan_done (scan_done)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Applies one beat to the mirror and returns the status the block should report.
    function automatic status_t advance_detector(input logic kind, input logic [CHAN_W-1:0] ch);
        status_t             res;
        logic                scanned;
        logic                err;
        logic [LANE_MAX-1:0] leds;
        logic [TIME_W-1:0]   since_online;
        logic [TIME_W-1:0]   since_heard;
        scanned = 1'b0;
        if (kind == REQ_TICK)
        begin
            now_ticks = now_ticks + TIME_W'(1);
            div_cnt = div_cnt + 8'd1;
            if (div_cnt >= period_cfg)
            begin
                div_cnt = '0;
                scanned = 1'b1;
                for (int i = 0; i < LANE_MAX; i++)
                begin
                    if (enable_cfg[i])
                    begin
                        since_online = now_ticks - settle_start[i];
                        since_heard = now_ticks - heard_at[i];
                        if (since_online < {24'd0, settle_cfg[8*i +: 8]})
                            lost_bits[i] = 1'b0;
                        else if (since_heard > {24'd0, limits_cfg[8*i +: 8]})
                            lost_bits[i] = 1'b1;
                        else
                            lost_bits[i] = 1'b0;
                    end
                end
                err = 1'b0;
                leds = '0;
                for (int i = 0; i < LANE_MAX; i++)
                begin
                    if (enable_cfg[i] && lost_bits[i])
                        err = 1'b1;
                    else
                        leds[i] = 1'b1;
                end
                flow_state = leds;
                blink_cnt = blink_cnt + BLINK_W'(1);
                if (blink_cnt == BLINK_SCANS_DEF)
                begin
                    red_state = err ? ~red_state : 1'b0;
                    blink_cnt = '0;
                end
                buzz_state = err;
            end
        end
        else
        begin
            heard_at[ch] = now_ticks;
            if (lost_bits[ch])
            begin
                lost_bits[ch] = 1'b0;
                settle_start[ch] = now_ticks;
            end
        end
        res.lost = lost_bits;
        res.flow = flow_state;
        res.red = red_state;
        res.buzz = buzz_state;
        res.scan = scanned;
        return res;
    endfunction

    // Mostly short pauses, now and then a long one.
    function automatic int pick_pause();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic void check_field(input string what, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
        end
    endfunction

    // Narrow registers get random junk above their low byte.
    function automatic logic [CFG_DATA_W-1:0] pad_byte(input logic [7:0] v);
        logic [CFG_DATA_W-1:0] word;
        word = {$urandom, $urandom};
        word[7:0] = v;
        return word;
    endfunction

    function automatic logic [7:0] pick_threshold(input int top);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'd0;
        if (r == 1)
            return 8'd255;
        return 8'($urandom_range(1, top));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_type <= REQ_TICK;
            channel <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                expected_status.push_back(advance_detector(req_type, channel));
                if (!gapless && $urandom_range(0, 2) == 0)
                    send_gap = pick_pause();
            end
            if (!req_valid || req_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_valid <= 1'b0;
                end
                else if (pending_beats.size() != 0)
                begin
                    next_beat = pending_beats.pop_front();
                    req_valid <= 1'b1;
                    req_type <= next_beat.kind;
                    channel <= next_beat.ch;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else if (hold_served != hold_asks)
        begin
            // Long hold-off so the block backs up and stalls its input.
            hold_served++;
            recv_stall = 120;
            rsp_ready <= 1'b0;
        end
        else if (recv_stall > 0)
        begin
            recv_stall--;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
            if (!gapless && $urandom_range(0, 3) == 0)
                recv_stall = pick_pause();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            results_seen++;
            if (expected_status.size() == 0)
            begin
                errors++;
                $display("%0t: status beat with nothing expected, actual lost_mask %0h",
                         $time, lost_mask);
            end
            else
            begin
                automatic status_t want = expected_status.pop_front();
                check_field("lost_mask", want.lost, lost_mask);
                check_field("flow_leds", want.flow, flow_leds);
                check_field("red_led", 8'(want.red), 8'(red_led));
                check_field("buzzer", 8'(want.buzz), 8'(buzzer));
                check_field("scan_done", 8'(want.scan), 8'(scan_done));
            end
        end
    end

    task automatic push_beat(input logic kind, input logic [CHAN_W-1:0] ch);
        beat_t b;
        b.kind = kind;
        b.ch = ch;
        pending_beats.push_back(b);
        beats_sent++;
    endtask

    task automatic push_ticks(input int count);
        for (int k = 0; k < count; k++)
            push_beat(REQ_TICK, CHAN_W'($urandom));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_OFFLINE: limits_cfg = value;
            REG_SETTLE:  settle_cfg = value;
            REG_ENABLE:  enable_cfg = value[7:0];
            REG_PERIOD:  period_cfg = value[7:0];
            default: ;
        endcase
    endtask

    // Waits until every beat sent has come back, then lets the pipeline settle.
    task automatic drain(input int extra);
        while (results_seen != beats_sent)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic randomize_setup();
        logic [63:0] lim;
        logic [63:0] stl;
        int          r;
        for (int b = 0; b < LANE_MAX; b++)
        begin
            lim[8*b +: 8] = pick_threshold(30);
            stl[8*b +: 8] = pick_threshold(12);
        end
        if ($urandom_range(0, 1))
            write_reg(REG_OFFLINE, lim);
        if ($urandom_range(0, 1))
            write_reg(REG_SETTLE, stl);
        if ($urandom_range(0, 1))
        begin
            r = $urandom_range(0, 5);
            write_reg(REG_ENABLE, pad_byte(r == 0 ? 8'h00 : r == 1 ? 8'hFF : 8'($urandom)));
        end
        if ($urandom_range(0, 1))
        begin
            r = $urandom_range(0, 7);
            write_reg(REG_PERIOD, pad_byte(r == 0 ? 8'd0 : r == 1 ? 8'd255 :
                                           8'($urandom_range(1, 6))));
        end
    endtask

    // Live channels send heartbeats often enough to stay present; the rest
    // only occasionally, so they drop out and come back through the settle window.
    task automatic queue_traffic(input int count);
        logic [LANE_MAX-1:0] alive;
        logic [CHAN_W-1:0]   ch;
        int                  tick_pct;
        alive = LANE_MAX'($urandom);
        tick_pct = $urandom_range(30, 70);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 99) < tick_pct)
                push_beat(REQ_TICK, CHAN_W'($urandom));
            else
            begin
                ch = CHAN_W'($urandom);
                if (alive != 0 && $urandom_range(0, 4) != 0)
                    while (!alive[ch])
                        ch = ch + CHAN_W'(1);
                push_beat(REQ_BEAT, ch);
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < LANE_MAX; i++)
        begin
            heard_at[i] = '0;
            settle_start[i] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Default setup: heartbeats on lost channels, a disabled channel, a full scan period.
        push_beat(REQ_BEAT, 3'd0);
        push_beat(REQ_BEAT, 3'd3);
        push_beat(REQ_BEAT, 3'd7);
        push_ticks(10);
        push_beat(REQ_BEAT, 3'd0);
        drain(4);

        // Zero thresholds and a zero scan period: every tick scans.
        write_reg(REG_OFFLINE, 64'd0);
        write_reg(REG_SETTLE, 64'd0);
        write_reg(REG_ENABLE, pad_byte(8'hFF));
        write_reg(REG_PERIOD, pad_byte(8'd0));
        push_beat(REQ_TICK, 3'd5);
        push_beat(REQ_BEAT, 3'd6);
        push_beat(REQ_TICK, 3'd1);
        drain(4);

        // Widest thresholds, long period, then a period below the divider.
        write_reg(REG_OFFLINE, '1);
        write_reg(REG_SETTLE, '1);
        write_reg(REG_PERIOD, pad_byte(8'd200));
        push_beat(REQ_BEAT, 3'd2);
        push_ticks(7);
        drain(4);
        write_reg(REG_PERIOD, pad_byte(8'd5));
        push_ticks(1);
        drain(4);

        for (int phase = 0; phase < 12; phase++)
        begin
            randomize_setup();
            gapless = (phase == 4) || ($urandom_range(0, 4) == 0);
            if (phase == 4)
                hold_asks++;
            queue_traffic(75);
            drain(4);
        end
        gapless = 1'b0;

        drain(10);
        if (expected_status.size() != 0)
        begin
            errors++;
            $display("%0t: %0d status beats never arrived", $time, expected_status.size());
        end
        if (errors == 0)
            $display("[multi_channel_offline_detector] OK");
        else
            $display("[multi_channel_offline_detector] ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("[multi_channel_offline_detector] ERROR");
        $finish;
    end

endmodule
